/* hdl/rie_pkg.sv */
// rie_pkg: opcodes, codes and transaction types shared by the execute unit
// no dependencies
package rie_pkg;

  localparam logic [5:0] OP_REGALU = 6'd57;
  localparam logic [5:0] OP_MULDIV = 6'd49;
  localparam logic [5:0] OP_PRIV   = 6'd41;
  localparam logic [4:0] LINK_REG  = 5'd31;
  localparam logic [31:0] TOP_BIT  = 32'h8000_0000;

  localparam logic [2:0] EXC_NONE  = 3'd0;
  localparam logic [2:0] EXC_SYS   = 3'd1;
  localparam logic [2:0] EXC_BRK   = 3'd2;
  localparam logic [2:0] EXC_INV   = 3'd3;
  localparam logic [2:0] EXC_PRIV  = 3'd4;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;

  localparam logic [3:0] FN_MOD    = 4'd11;
  localparam logic [3:0] FN_SDIV   = 4'd12;
  localparam logic [3:0] FN_UDIV   = 4'd13;
  localparam logic [3:0] FN_MUL    = 4'd15;

  typedef struct packed {
    logic        we;
    logic [4:0]  wi;
    logic [31:0] wv;
    logic [31:0] npc;
    logic [2:0]  exc;
    logic [1:0]  mk;
    logic [1:0]  ms;
    logic [31:0] ma;
    logic [31:0] sd;
  } res_t;

  typedef struct packed {
    logic dv;
    logic dmod;
    logic dzero;
    logic dneg;
  } divctl_t;

endpackage

/* hdl/risc_instruction_execute_unit.sv */
// risc_instruction_execute_unit: pipelined decode/execute of one instruction per cycle
// depends on rie_pkg (opcodes, result struct); contains a 32-stage restoring divider
//
// channel  | ports                                   | flow
// ---------+-----------------------------------------+------------------------------
// input    | in_start, busy, in_* fields             | taken when in_start && !busy
// result   | out_valid, out_* fields                 | one-cycle strobe, no backpressure
//
// one transaction may enter every cycle; busy is always low
// every instruction passes the input register, the execute stage,
// 32 divider stages (one quotient bit each) and the output register
// all instructions ride the divider stages so results leave in order
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so the pipeline never holds
module risc_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_pc_value,
  input  logic [31:0] in_dest_field_value,
  input  logic [31:0] in_srca_value,
  input  logic [31:0] in_srcb_value,
  output logic        out_valid,
  output logic        out_write_enable,
  output logic [4:0]  out_write_index,
  output logic [31:0] out_write_value,
  output logic [31:0] out_next_pc,
  output logic [2:0]  out_exception_code,
  output logic [1:0]  out_mem_kind,
  output logic [1:0]  out_mem_size,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_store_data
);

  localparam int DivStages = 32;

  // input register
  logic        a_vld_r;
  logic [31:0] a_ir_r, a_pc_r, a_vd_r, a_va_r, a_vb_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_start;
    end
  end

  always_ff @(posedge clk) begin
    a_ir_r <= in_instr_word;
    a_pc_r <= in_pc_value;
    a_vd_r <= in_dest_field_value;
    a_va_r <= in_srca_value;
    a_vb_r <= in_srcb_value;
  end

  // execute stage: everything but the divide iterations
  rie_pkg::res_t    res_nxt;
  rie_pkg::divctl_t dctl_nxt;
  logic [31:0] dvd_nxt, dsr_nxt;

  logic [2:0]  maj;
  logic [5:0]  op;
  logic [3:0]  fn;
  logic [4:0]  rd, ra;
  logic [1:0]  kind;
  logic [31:0] imm, boff, imm5, jtgt, pc4, val, shreg, r;
  logic [31:0] ma_abs, mb_abs;
  logic        taken, isw, isl, iss, w;

  function automatic logic [31:0] shift_op(input logic [1:0] k, input logic [31:0] x,
                                           input logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    case (k)
      2'd0:    shift_op = x << n;
      2'd1:    shift_op = x >> n;
      2'd2:    shift_op = 32'($signed(x) >>> n);
      default: shift_op = dbl[31:0];
    endcase
  endfunction

  function automatic logic slt(input logic [31:0] x, input logic [31:0] y);
    slt = $signed(x) < $signed(y);
  endfunction

  always_comb begin
    maj   = a_ir_r[2:0];
    op    = a_ir_r[5:0];
    fn    = a_ir_r[31:28];
    rd    = a_ir_r[10:6];
    ra    = a_ir_r[15:11];
    kind  = a_ir_r[27:26];
    imm   = {16'd0, a_ir_r[31:16]};
    boff  = {{14{a_ir_r[31]}}, a_ir_r[31:16], 2'b00};
    imm5  = {{27{ra[4]}}, ra};
    jtgt  = {a_pc_r[31], a_ir_r[31:3], 2'b00};
    pc4   = a_pc_r + 32'd4;
    val   = shift_op(kind, a_vb_r, a_ir_r[25:21]);
    shreg = shift_op(kind, a_vb_r, a_va_r[4:0]);
    ma_abs = a_va_r[31] ? (32'd0 - a_va_r) : a_va_r;
    mb_abs = a_vb_r[31] ? (32'd0 - a_vb_r) : a_vb_r;

    res_nxt  = '0;
    res_nxt.npc = pc4;
    dctl_nxt = '0;
    dvd_nxt  = a_va_r;
    dsr_nxt  = a_vb_r;
    taken = 1'b0;
    isw   = 1'b0;
    isl   = 1'b0;
    iss   = 1'b0;
    w     = 1'b1;
    r     = '0;

    if (maj == 3'd7) begin
      // jump and link
      res_nxt.we  = 1'b1;
      res_nxt.wi  = rie_pkg::LINK_REG;
      res_nxt.wv  = pc4;
      res_nxt.npc = jtgt;
    end else if (maj == 3'd6) begin
      res_nxt.npc = jtgt;
    end else if (op == rie_pkg::OP_REGALU) begin
      if (rd != 5'd0 || (fn >= 4'd9 && fn <= 4'd11)) begin
        case (fn)
          4'd0:  r = ~(a_va_r | val);
          4'd1:  r = a_va_r | val;
          4'd2:  r = a_va_r ^ val;
          4'd3:  r = a_va_r & val;
          4'd4:  r = {31'd0, slt(a_va_r, val)};
          4'd5:  r = {31'd0, a_va_r < val};
          4'd6:  r = a_va_r - val;
          4'd7:  r = a_va_r + val;
          4'd8:  r = shreg;
          4'd9, 4'd10, 4'd11: begin
            w = 1'b0;
            res_nxt.mk = rie_pkg::MEM_STORE;
            res_nxt.ms = 2'(4'd11 - fn);
            res_nxt.ma = a_va_r + val;
            res_nxt.sd = a_vd_r;
          end
          4'd12: begin
            w = 1'b0;
            res_nxt.exc = rie_pkg::EXC_INV;
          end
          default: begin
            w = 1'b0;
            res_nxt.mk = rie_pkg::MEM_LOAD;
            res_nxt.ms = 2'(4'd15 - fn);
            res_nxt.ma = a_va_r + val;
            res_nxt.wi = rd;
          end
        endcase
        if (w) begin
          res_nxt.we = 1'b1;
          res_nxt.wi = rd;
          res_nxt.wv = r;
        end
      end
    end else if (op == rie_pkg::OP_MULDIV) begin
      case (fn)
        4'd0: begin
          w = 1'b0;
          res_nxt.exc = rie_pkg::EXC_SYS;
        end
        4'd1: begin
          w = 1'b0;
          res_nxt.exc = rie_pkg::EXC_BRK;
        end
        rie_pkg::FN_MOD: begin
          // fallback value for mod by zero is the dividend
          r = a_va_r;
          dctl_nxt.dv   = 1'b1;
          dctl_nxt.dmod = 1'b1;
        end
        rie_pkg::FN_SDIV: begin
          r = 32'hFFFF_FFFF;
          dctl_nxt.dv   = 1'b1;
          dctl_nxt.dneg = a_va_r[31] ^ a_vb_r[31];
          dvd_nxt = ma_abs;
          dsr_nxt = mb_abs;
        end
        rie_pkg::FN_UDIV: begin
          r = 32'hFFFF_FFFF;
          dctl_nxt.dv = 1'b1;
        end
        rie_pkg::FN_MUL: r = a_va_r * a_vb_r;
        default: begin
          w = 1'b0;
          res_nxt.exc = rie_pkg::EXC_INV;
        end
      endcase
      dctl_nxt.dzero = (a_vb_r == 32'd0);
      if (w && rd != 5'd0) begin
        res_nxt.we = 1'b1;
        res_nxt.wi = rd;
        res_nxt.wv = r;
      end else begin
        dctl_nxt.dv = 1'b0;
      end
    end else if (op == rie_pkg::OP_PRIV) begin
      res_nxt.exc = rie_pkg::EXC_PRIV;
    end else begin
      case (op)
        6'd61: taken = (a_vd_r == a_va_r);
        6'd53: taken = (a_vd_r != a_va_r);
        6'd45: taken = (a_vd_r < a_va_r);
        6'd37: taken = slt(a_vd_r, a_va_r);
        6'd29: taken = (a_vd_r == imm5);
        6'd21: taken = (a_vd_r != imm5);
        6'd13: taken = (a_vd_r < imm5);
        6'd5:  taken = slt(a_vd_r, imm5);
        6'd60: begin isw = 1'b1; r = a_va_r + imm; end
        6'd52: begin isw = 1'b1; r = a_va_r - imm; end
        6'd44: begin isw = 1'b1; r = {31'd0, a_va_r < imm}; end
        6'd36: begin
          isw = 1'b1;
          r = {31'd0, slt(a_va_r, {{16{imm[15]}}, imm[15:0]})};
        end
        6'd28: begin isw = 1'b1; r = a_va_r & imm; end
        6'd20: begin isw = 1'b1; r = a_va_r ^ imm; end
        6'd12: begin isw = 1'b1; r = a_va_r | imm; end
        6'd4:  begin isw = 1'b1; r = a_va_r | {imm[15:0], 16'd0}; end
        6'd59: begin
          isl = 1'b1; res_nxt.ms = rie_pkg::SZ_BYTE; res_nxt.ma = a_va_r + imm;
        end
        6'd51: begin
          isl = 1'b1; res_nxt.ms = rie_pkg::SZ_HALF;
          res_nxt.ma = a_va_r + {imm[30:0], 1'b0};
        end
        6'd43: begin
          isl = 1'b1; res_nxt.ms = rie_pkg::SZ_WORD;
          res_nxt.ma = a_va_r + {imm[29:0], 2'b00};
        end
        6'd58: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_BYTE;
          res_nxt.ma = a_vd_r + imm; res_nxt.sd = a_va_r;
        end
        6'd50: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_HALF;
          res_nxt.ma = a_vd_r + {imm[30:0], 1'b0}; res_nxt.sd = a_va_r;
        end
        6'd42: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_WORD;
          res_nxt.ma = a_vd_r + {imm[29:0], 2'b00}; res_nxt.sd = a_va_r;
        end
        6'd26: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_BYTE;
          res_nxt.ma = a_vd_r + imm; res_nxt.sd = imm5;
        end
        6'd18: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_HALF;
          res_nxt.ma = a_vd_r + {imm[30:0], 1'b0}; res_nxt.sd = imm5;
        end
        6'd10: begin
          iss = 1'b1; res_nxt.ms = rie_pkg::SZ_WORD;
          res_nxt.ma = a_vd_r + {imm[29:0], 2'b00}; res_nxt.sd = imm5;
        end
        6'd56: begin
          // register jump and link
          isw = 1'b1; r = pc4; res_nxt.npc = a_va_r + boff;
        end
        default: res_nxt.exc = rie_pkg::EXC_INV;
      endcase
      if (taken) begin
        res_nxt.npc = a_pc_r + boff;
      end
      if (isw && rd != 5'd0) begin
        res_nxt.we = 1'b1;
        res_nxt.wi = rd;
        res_nxt.wv = r;
      end
      if (isl) begin
        if (rd != 5'd0) begin
          res_nxt.mk = rie_pkg::MEM_LOAD;
          res_nxt.wi = rd;
        end else begin
          res_nxt.ms = rie_pkg::SZ_BYTE;
          res_nxt.ma = '0;
        end
      end
      if (iss) begin
        res_nxt.mk = rie_pkg::MEM_STORE;
      end
    end
  end

  // divider pipeline: stage k holds partial remainder and shifting dividend/quotient
  logic             vld_r  [0:DivStages];
  rie_pkg::res_t    pay_r  [0:DivStages];
  rie_pkg::divctl_t dctl_r [0:DivStages];
  logic [31:0]      rem_r  [0:DivStages];
  logic [31:0]      quo_r  [0:DivStages];
  logic [31:0]      dsr_r  [0:DivStages];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pay_r[0]  <= res_nxt;
    dctl_r[0] <= dctl_nxt;
    rem_r[0]  <= '0;
    quo_r[0]  <= dvd_nxt;
    dsr_r[0]  <= dsr_nxt;
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
      trial = {rem_r[k], quo_r[k][31]};
      diff  = trial - {1'b0, dsr_r[k]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      pay_r[k+1]  <= pay_r[k];
      dctl_r[k+1] <= dctl_r[k];
      dsr_r[k+1]  <= dsr_r[k];
      if (!diff[32]) begin
        rem_r[k+1] <= diff[31:0];
        quo_r[k+1] <= {quo_r[k][30:0], 1'b1};
      end else begin
        rem_r[k+1] <= trial[31:0];
        quo_r[k+1] <= {quo_r[k][30:0], 1'b0};
      end
    end
  end

  // output register: pick divide result, fix the sign
  rie_pkg::res_t fin_nxt, out_r;
  logic          out_vld_r;

  always_comb begin
    fin_nxt = pay_r[DivStages];
    if (dctl_r[DivStages].dv && !dctl_r[DivStages].dzero) begin
      if (dctl_r[DivStages].dmod) begin
        fin_nxt.wv = rem_r[DivStages];
      end else if (dctl_r[DivStages].dneg) begin
        fin_nxt.wv = 32'd0 - quo_r[DivStages];
      end else begin
        fin_nxt.wv = quo_r[DivStages];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[DivStages];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= fin_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_write_enable   = out_r.we;
  assign out_write_index    = out_r.wi;
  assign out_write_value    = out_r.wv;
  assign out_next_pc        = out_r.npc;
  assign out_exception_code = out_r.exc;
  assign out_mem_kind       = out_r.mk;
  assign out_mem_size       = out_r.ms;
  assign out_mem_address    = out_r.ma;
  assign out_store_data     = out_r.sd;

endmodule

/* bench/rie_checker.sv */
`timescale 1ns / 1ps
// rie_checker: watches the execute unit's channels, predicts each result and compares
// depends on rie_pkg (opcodes, codes, result struct)
module rie_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  input  logic        busy,
  input  logic [31:0] in_instr_word,
  input  logic [31:0] in_pc_value,
  input  logic [31:0] in_dest_field_value,
  input  logic [31:0] in_srca_value,
  input  logic [31:0] in_srcb_value,
  input  logic        out_valid,
  input  logic        out_write_enable,
  input  logic [4:0]  out_write_index,
  input  logic [31:0] out_write_value,
  input  logic [31:0] out_next_pc,
  input  logic [2:0]  out_exception_code,
  input  logic [1:0]  out_mem_kind,
  input  logic [1:0]  out_mem_size,
  input  logic [31:0] out_mem_address,
  input  logic [31:0] out_store_data,
  output int          fail_count,
  output int          pending_count
);

  rie_pkg::res_t exec_results_q[$];

  function automatic logic [31:0] shifted(logic [1:0] kind, logic [31:0] x, logic [4:0] n);
    case (kind)
      2'd0: return x << n;
      2'd1: return x >> n;
      2'd2: return $unsigned($signed(x) >>> n);
      default: return (x >> n) | (x << (6'd32 - n));
    endcase
  endfunction

  function automatic logic lt_signed(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] quot_signed(logic [31:0] a, logic [31:0] b);
    logic [31:0] ua, ub, q;
    if (b == 0) return '1;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic rie_pkg::res_t execute(logic [31:0] ir, logic [31:0] pc,
                                            logic [31:0] vd, logic [31:0] va,
                                            logic [31:0] vb);
    rie_pkg::res_t r;
    logic [5:0] op;
    logic [3:0] fn;
    logic [4:0] rd;
    logic [15:0] imm16;
    logic [31:0] imm, boff, imm5, val, v;
    logic [1:0] kind;
    logic wr, taken, isw, isl, iss;
    r = '0;
    r.npc = pc + 4;
    op = ir[5:0];
    fn = ir[31:28];
    rd = ir[10:6];
    imm16 = ir[31:16];
    imm = {16'd0, imm16};
    boff = {{14{imm16[15]}}, imm16, 2'b00};
    imm5 = {{27{ir[15]}}, ir[15:11]};
    v = 0;
    wr = 1;
    taken = 0; isw = 0; isl = 0; iss = 0;
    if (ir[2:0] == 3'd7) begin
      r.we = 1; r.wi = rie_pkg::LINK_REG; r.wv = pc + 4;
      r.npc = (pc & rie_pkg::TOP_BIT) | {ir[31:3], 2'b00};
    end else if (ir[2:0] == 3'd6) begin
      r.npc = (pc & rie_pkg::TOP_BIT) | {ir[31:3], 2'b00};
    end else if (op == rie_pkg::OP_REGALU) begin
      kind = ir[27:26];
      val = shifted(kind, vb, ir[25:21]);
      if (rd != 0 || (fn >= 9 && fn <= 11)) begin
        case (fn)
          4'd0: v = ~(va | val);
          4'd1: v = va | val;
          4'd2: v = va ^ val;
          4'd3: v = va & val;
          4'd4: v = {31'd0, lt_signed(va, val)};
          4'd5: v = {31'd0, va < val};
          4'd6: v = va - val;
          4'd7: v = va + val;
          4'd8: v = shifted(kind, vb, va[4:0]);
          4'd9, 4'd10, 4'd11: begin
            wr = 0; r.mk = rie_pkg::MEM_STORE; r.ms = 2'(11 - fn); r.ma = va + val;
            r.sd = vd;
          end
          4'd12: begin
            wr = 0; r.exc = rie_pkg::EXC_INV;
          end
          default: begin
            wr = 0; r.mk = rie_pkg::MEM_LOAD; r.ms = 2'(15 - fn); r.ma = va + val;
            r.wi = rd;
          end
        endcase
        if (wr) begin
          r.we = 1; r.wi = rd; r.wv = v;
        end
      end
    end else if (op == rie_pkg::OP_MULDIV) begin
      case (fn)
        4'd0: begin wr = 0; r.exc = rie_pkg::EXC_SYS; end
        4'd1: begin wr = 0; r.exc = rie_pkg::EXC_BRK; end
        rie_pkg::FN_MOD:  v = (vb == 0) ? va : va % vb;
        rie_pkg::FN_SDIV: v = quot_signed(va, vb);
        rie_pkg::FN_UDIV: v = (vb == 0) ? '1 : va / vb;
        rie_pkg::FN_MUL:  v = va * vb;
        default: begin wr = 0; r.exc = rie_pkg::EXC_INV; end
      endcase
      if (wr && rd != 0) begin
        r.we = 1; r.wi = rd; r.wv = v;
      end
    end else if (op == rie_pkg::OP_PRIV) begin
      r.exc = rie_pkg::EXC_PRIV;
    end else begin
      case (op)
        6'd61: taken = vd == va;
        6'd53: taken = vd != va;
        6'd45: taken = vd < va;
        6'd37: taken = lt_signed(vd, va);
        6'd29: taken = vd == imm5;
        6'd21: taken = vd != imm5;
        6'd13: taken = vd < imm5;
        6'd5:  taken = lt_signed(vd, imm5);
        6'd60: begin isw = 1; v = va + imm; end
        6'd52: begin isw = 1; v = va - imm; end
        6'd44: begin isw = 1; v = {31'd0, va < imm}; end
        6'd36: begin isw = 1; v = {31'd0, lt_signed(va, {{16{imm16[15]}}, imm16})}; end
        6'd28: begin isw = 1; v = va & imm; end
        6'd20: begin isw = 1; v = va ^ imm; end
        6'd12: begin isw = 1; v = va | imm; end
        6'd4:  begin isw = 1; v = va | (imm << 16); end
        6'd59: begin isl = 1; r.ms = rie_pkg::SZ_BYTE; r.ma = va + imm; end
        6'd51: begin isl = 1; r.ms = rie_pkg::SZ_HALF; r.ma = va + (imm << 1); end
        6'd43: begin isl = 1; r.ms = rie_pkg::SZ_WORD; r.ma = va + (imm << 2); end
        6'd58: begin iss = 1; r.ms = rie_pkg::SZ_BYTE; r.ma = vd + imm; r.sd = va; end
        6'd50: begin
          iss = 1; r.ms = rie_pkg::SZ_HALF; r.ma = vd + (imm << 1); r.sd = va;
        end
        6'd42: begin
          iss = 1; r.ms = rie_pkg::SZ_WORD; r.ma = vd + (imm << 2); r.sd = va;
        end
        6'd26: begin iss = 1; r.ms = rie_pkg::SZ_BYTE; r.ma = vd + imm; r.sd = imm5; end
        6'd18: begin
          iss = 1; r.ms = rie_pkg::SZ_HALF; r.ma = vd + (imm << 1); r.sd = imm5;
        end
        6'd10: begin
          iss = 1; r.ms = rie_pkg::SZ_WORD; r.ma = vd + (imm << 2); r.sd = imm5;
        end
        6'd56: begin isw = 1; v = pc + 4; r.npc = va + boff; end
        default: r.exc = rie_pkg::EXC_INV;
      endcase
      if (taken) r.npc = pc + boff;
      if (isw && rd != 0) begin
        r.we = 1; r.wi = rd; r.wv = v;
      end
      if (isl) begin
        if (rd != 0) begin
          r.mk = rie_pkg::MEM_LOAD; r.wi = rd;
        end else begin
          r.ms = rie_pkg::SZ_BYTE; r.ma = 0;
        end
      end
      if (iss) r.mk = rie_pkg::MEM_STORE;
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rie_pkg::res_t e;
    if (rst_n) begin
      if (out_valid) begin
        if (exec_results_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count++;
        end else begin
          e = exec_results_q.pop_front();
          compare_field("write_enable", 32'(e.we), 32'(out_write_enable));
          compare_field("write_index", 32'(e.wi), 32'(out_write_index));
          compare_field("write_value", e.wv, out_write_value);
          compare_field("next_pc", e.npc, out_next_pc);
          compare_field("exception_code", 32'(e.exc), 32'(out_exception_code));
          compare_field("mem_kind", 32'(e.mk), 32'(out_mem_kind));
          compare_field("mem_size", 32'(e.ms), 32'(out_mem_size));
          compare_field("mem_address", e.ma, out_mem_address);
          compare_field("store_data", e.sd, out_store_data);
        end
      end
      if (in_start && !busy)
        exec_results_q.push_back(execute(in_instr_word, in_pc_value, in_dest_field_value,
                                         in_srca_value, in_srcb_value));
    end
    pending_count = exec_results_q.size();
  end

endmodule

/* bench/tb_risc_instruction_execute_unit.sv */
`timescale 1ns / 1ps
// tb_risc_instruction_execute_unit: stimulus and verdict for the execute unit
// depends on rie_pkg, risc_instruction_execute_unit and rie_checker
module tb_risc_instruction_execute_unit;

  logic        clk;
  logic        rst_n;
  logic        in_start;
  logic        busy;
  logic [31:0] in_instr_word, in_pc_value, in_dest_field_value, in_srca_value, in_srcb_value;
  logic        out_valid, out_write_enable;
  logic [4:0]  out_write_index;
  logic [31:0] out_write_value, out_next_pc, out_mem_address, out_store_data;
  logic [2:0]  out_exception_code;
  logic [1:0]  out_mem_kind, out_mem_size;
  int          fail_count, pending_count;
  int          idle_pct;

  // all opcodes the decoder knows (plain, group and jump), used to bias random words
  logic [5:0] known_ops[] = '{6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21, 6'd13, 6'd5,
                              6'd60, 6'd52, 6'd44, 6'd36, 6'd28, 6'd20, 6'd12, 6'd4,
                              6'd59, 6'd51, 6'd43, 6'd58, 6'd50, 6'd42, 6'd26, 6'd18,
                              6'd10, 6'd56, rie_pkg::OP_REGALU, rie_pkg::OP_MULDIV,
                              rie_pkg::OP_PRIV, 6'd7, 6'd6};

  risc_instruction_execute_unit dut (.*);

  rie_checker checker_i (.*);

  // clock: 10 ns period
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // safety net well past the slowest legal run
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // random operand with frequent corner values
  function automatic logic [31:0] operand();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return '1;
      2: return rie_pkg::TOP_BIT;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // one transaction: wait for acceptance, with random idle cycles before it
  task automatic issue(logic [31:0] ir, logic [31:0] pc, logic [31:0] vd,
                       logic [31:0] va, logic [31:0] vb);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_start <= 0;
      @(posedge clk);
    end
    in_start            <= 1;
    in_instr_word       <= ir;
    in_pc_value         <= pc;
    in_dest_field_value <= vd;
    in_srca_value       <= va;
    in_srcb_value       <= vb;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // random word: mostly known opcodes or group functions, some pure noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) != 0) w[5:0] = known_ops[$urandom_range(0, known_ops.size() - 1)];
    if ($urandom_range(0, 3) == 0) w[10:6] = 0;   // destination zero cases
    return w;
  endfunction

  initial begin
    int k;
    rst_n = 0;
    in_start = 0;
    in_instr_word = 0;
    in_pc_value = 0;
    in_dest_field_value = 0;
    in_srca_value = 0;
    in_srcb_value = 0;
    idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: group functions, corner divides, register-group cases, privileged, jumps, branch, load
    for (k = 0; k < 16; k++)
      issue({4'(k), 7'h0, 5'd2, 5'd1, 5'd3, rie_pkg::OP_MULDIV}, 32'h100, 0,
            rie_pkg::TOP_BIT, (k == 13) ? 32'd0 : '1);
    issue({rie_pkg::FN_MOD, 7'h0, 5'd2, 5'd1, 5'd3, rie_pkg::OP_MULDIV}, 0, 0, 32'd77, 32'd0);
    issue({4'd12, 22'h0, rie_pkg::OP_REGALU}, 0, 0, 0, 0);    // invalid fn with rd zero
    issue({4'd12, 7'h0, 5'd0, 5'd0, 5'd4, rie_pkg::OP_REGALU}, 0, 0, 0, 0);
    issue({4'd8, 2'd3, 5'd0, 5'd0, 5'd0, 5'd5, rie_pkg::OP_REGALU}, 0, 0, 32'd33,
          32'h8000_0001);
    issue({4'd7, 2'd2, 5'd31, 5'd0, 5'd0, 5'd5, rie_pkg::OP_REGALU}, 0, 0, 0,
          rie_pkg::TOP_BIT);
    issue({4'd3, 22'h0, rie_pkg::OP_PRIV}, 0, 0, 0, 0);
    issue('1, '1, 0, 0, 0);                                   // jump and link
    issue({29'h1234, 3'd6}, rie_pkg::TOP_BIT, 0, 0, 0);
    issue({16'h8000, 5'd31, 5'd0, 6'd37}, 32'h10, rie_pkg::TOP_BIT, 0, 0);
    issue({16'hffff, 5'd0, 5'd0, 6'd59}, 0, 0, '1, 0);       // load to rd zero

    // random: three idle profiles
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 53 : 0;
      for (k = 0; k < 580; k++)
        issue(random_word(), $urandom, operand(), operand(), operand());
    end
    in_start <= 0;

    // drain, then wait before the verdict
    k = 0;
    while (pending_count != 0 && k < 1000) begin
      @(posedge clk);
      k++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
